/* design/cttu_pkg.sv */
package cttu_pkg;

    localparam logic [15:0] ACTIVE_MARK = 16'hFFFF;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_FULL      = 2'd1;
    localparam logic [1:0] RC_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic [63:0] part;
        logic [63:0] coll;
        logic [15:0] act;
        logic [15:0] sta;
    } t_entry;

    typedef struct packed {
        logic cmp;
        logic apply;
        logic start;
        logic finish;
        logic full;
        logic victim_ok;
    } t_cell_ctl;

endpackage

/* design/command_tracking_table_unit.sv */
// A word passes a compare state, then an apply state (held while the output
// stalls); a new word is taken when idle or in the apply state. Compare
// registers hit and completed flags in all cells; apply resolves first match
// along the chain, shifts/updates the cells and loads the output register.
// Reset (synchronous, active low) empties the table and drops any result.
module command_tracking_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_partition_id,
    input  logic [63:0] i_collection_id,
    input  logic [15:0] i_action_code,
    input  logic [15:0] i_end_status,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_code,
    output logic [15:0] o_found_action,
    output logic [15:0] o_found_status,
    output logic        o_is_active
);

    cttu_pkg::t_state    r_state, n_state;
    logic [1:0]          r_op;
    logic [63:0]         r_part;
    logic [63:0]         r_coll;
    logic [15:0]         r_act;
    logic [15:0]         r_fin;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_code, n_code;
    logic [15:0]         r_fact, n_fact;
    logic [15:0]         r_fsta, n_fsta;
    logic                r_fact_on, n_fact_on;

    logic                accept;
    logic                out_free;
    logic                apply;
    logic                is_start;
    logic                is_finish;
    logic                full;
    cttu_pkg::t_cell_ctl ctl;
    cttu_pkg::t_entry    new_ent;

    cttu_pkg::t_entry    ent     [TABLE_DEPTH];
    logic                vld     [TABLE_DEPTH];
    logic                hit_b   [TABLE_DEPTH+1];
    logic                done_b  [TABLE_DEPTH+1];
    logic [15:0]         acc_act [TABLE_DEPTH+1];
    logic [15:0]         acc_sta [TABLE_DEPTH+1];

    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = ~((r_state == cttu_pkg::ST_IDLE) ||
                          ((r_state == cttu_pkg::ST_APPLY) && out_free));
    assign accept     = i_in_valid & ~o_in_stall;
    assign apply      = (r_state == cttu_pkg::ST_APPLY) & out_free;
    assign is_start   = (r_op == cttu_pkg::OP_START);
    assign is_finish  = (r_op == cttu_pkg::OP_FINISH);
    assign full       = vld[TABLE_DEPTH-1];

    assign new_ent = '{part: r_part, coll: r_coll, act: r_act, sta: cttu_pkg::ACTIVE_MARK};

    assign ctl.cmp       = (r_state == cttu_pkg::ST_CMP);
    assign ctl.apply     = apply;
    assign ctl.start     = is_start;
    assign ctl.finish    = is_finish;
    assign ctl.full      = full;
    assign ctl.victim_ok = done_b[TABLE_DEPTH];

    assign hit_b[0]   = 1'b0;
    assign done_b[0]  = 1'b0;
    assign acc_act[0] = 16'd0;
    assign acc_sta[0] = 16'd0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        cttu_pkg::t_entry nxt;
        logic             prev_valid;
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign nxt = new_ent;
        end else begin : g_mid
            assign nxt = ent[g+1];
        end
        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = vld[g-1];
        end
        cttu_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new         (new_ent),
            .i_nxt         (nxt),
            .i_fin         (r_fin),
            .i_prev_valid  (prev_valid),
            .i_hit_before  (hit_b[g]),
            .i_done_before (done_b[g]),
            .i_acc_act     (acc_act[g]),
            .i_acc_sta     (acc_sta[g]),
            .o_valid       (vld[g]),
            .o_ent         (ent[g]),
            .o_hit_before  (hit_b[g+1]),
            .o_done_before (done_b[g+1]),
            .o_acc_act     (acc_act[g+1]),
            .o_acc_sta     (acc_sta[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_out_stall;
        n_code      = r_code;
        n_fact      = r_fact;
        n_fsta      = r_fsta;
        n_fact_on   = r_fact_on;
        case (r_state)
            cttu_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = cttu_pkg::ST_CMP;
                end
            end
            cttu_pkg::ST_CMP: begin
                n_state = cttu_pkg::ST_APPLY;
            end
            cttu_pkg::ST_APPLY: begin
                if (apply) begin
                    n_state     = accept ? cttu_pkg::ST_CMP : cttu_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    if (is_start) begin
                        if (!full || done_b[TABLE_DEPTH]) begin
                            n_code    = cttu_pkg::RC_OK;
                            n_fact    = r_act;
                            n_fsta    = cttu_pkg::ACTIVE_MARK;
                            n_fact_on = 1'b1;
                        end else begin
                            n_code    = cttu_pkg::RC_FULL;
                            n_fact    = 16'd0;
                            n_fsta    = 16'd0;
                            n_fact_on = 1'b0;
                        end
                    end else if (hit_b[TABLE_DEPTH]) begin
                        n_code    = cttu_pkg::RC_OK;
                        n_fact    = acc_act[TABLE_DEPTH];
                        n_fsta    = is_finish ? r_fin : acc_sta[TABLE_DEPTH];
                        n_fact_on = (n_fsta == cttu_pkg::ACTIVE_MARK);
                    end else begin
                        n_code    = cttu_pkg::RC_NOT_FOUND;
                        n_fact    = 16'd0;
                        n_fsta    = 16'd0;
                        n_fact_on = 1'b0;
                    end
                end
            end
            default: begin
                n_state = cttu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cttu_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_part <= i_partition_id;
            r_coll <= i_collection_id;
            r_act  <= i_action_code;
            r_fin  <= i_end_status;
        end
        r_code    <= n_code;
        r_fact    <= n_fact;
        r_fsta    <= n_fsta;
        r_fact_on <= n_fact_on;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_code  = r_code;
    assign o_found_action = r_fact;
    assign o_found_status = r_fsta;
    assign o_is_active    = r_fact_on;

endmodule

/* design/cttu_cell.sv */
module cttu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cttu_pkg::t_cell_ctl i_ctl,
    input  cttu_pkg::t_entry    i_new,
    input  cttu_pkg::t_entry    i_nxt,
    input  logic [15:0]         i_fin,
    input  logic                i_prev_valid,
    input  logic                i_hit_before,
    input  logic                i_done_before,
    input  logic [15:0]         i_acc_act,
    input  logic [15:0]         i_acc_sta,
    output logic                o_valid,
    output cttu_pkg::t_entry    o_ent,
    output logic                o_hit_before,
    output logic                o_done_before,
    output logic [15:0]         o_acc_act,
    output logic [15:0]         o_acc_sta
);

    logic             r_valid, n_valid;
    logic             r_hit, n_hit;
    logic             r_done, n_done;
    cttu_pkg::t_entry r_ent, n_ent;
    logic             sel;
    logic             shift;
    logic             append;

    assign sel    = r_hit & ~i_hit_before;
    assign shift  = i_ctl.start & i_ctl.full & i_ctl.victim_ok & (i_done_before | r_done);
    assign append = i_ctl.start & ~i_ctl.full & ~r_valid & i_prev_valid;

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        n_hit   = r_hit;
        n_done  = r_done;
        if (i_ctl.cmp) begin
            n_hit  = r_valid & (r_ent.part == i_new.part) & (r_ent.coll == i_new.coll);
            n_done = r_valid & (r_ent.sta != cttu_pkg::ACTIVE_MARK);
        end
        if (i_ctl.apply) begin
            if (append) begin
                n_ent   = i_new;
                n_valid = 1'b1;
            end else if (shift) begin
                n_ent = i_nxt;
            end else if (i_ctl.finish & sel) begin
                n_ent.sta = i_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= n_hit;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_valid       = r_valid;
    assign o_ent         = r_ent;
    assign o_hit_before  = i_hit_before | r_hit;
    assign o_done_before = i_done_before | r_done;
    assign o_acc_act     = i_acc_act | (sel ? r_ent.act : 16'd0);
    assign o_acc_sta     = i_acc_sta | (sel ? r_ent.sta : 16'd0);

endmodule
